[hdl/pfe_pkg.sv]
// Shared types, letter constants and configuration indexes for the Playfair
// digraph encryptor. No dependencies; every other file refers to this package.
`default_nettype none

package pfe_pkg;

  localparam int LETTER_W = 5;
  localparam int SIDE     = 5;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [2:0]          coord_t;

  // Square cell k sits at grid[k / 5][k % 5]; grid[0][0] is the lowest bits.
  typedef letter_t [SIDE-1:0]   grid_row_t;
  typedef grid_row_t [SIDE-1:0] grid_t;

  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_SQUARE_LOW  = 2'd0;
  localparam cfg_index_t CFG_SQUARE_MID  = 2'd1;
  localparam cfg_index_t CFG_SQUARE_HIGH = 2'd2;

  localparam int CFG_WIDE_W   = 50;
  localparam int CFG_NARROW_W = 25;

  // One formed digraph waiting for encryption.
  typedef struct packed {
    logic    emit;    // the item produces ciphertext
    logic    dup;     // the same pair is sent twice (split on the last letter)
    logic    fin;     // the item ends the message
    letter_t first;
    letter_t second;
  } pair_t;

  // One encrypted digraph handed to the output queue.
  typedef struct packed {
    logic    dup;
    logic    fin;
    letter_t first;
    letter_t second;
  } q_load_t;

  function automatic letter_t fold_j(letter_t v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

endpackage

`default_nettype wire

[hdl/pfe_pair_former.sv]
// Input register stage: folds j into i, tracks the held first letter and forms
// the digraph for each transaction. Depends on pfe_pkg.
`default_nettype none

module pfe_pair_former (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pfe_pkg::letter_t in_letter,
  input  wire logic             in_end_of_text,
  input  wire logic             pair_take,
  output logic                  pair_valid,
  output pfe_pkg::pair_t        pair
);

  logic             open_r, open_nxt;
  pfe_pkg::letter_t held_r;
  logic             pv_r, pv_nxt;
  pfe_pkg::pair_t   pair_r, pair_nxt;
  pfe_pkg::letter_t letter_f;
  logic             accept;
  logic             split;

  assign in_stall = pv_r && !pair_take;
  assign accept   = in_valid && !in_stall;
  assign letter_f = pfe_pkg::fold_j(in_letter);

  // A repeated letter other than x is split with an x filler.
  assign split = open_r && (letter_f == held_r) && (letter_f != pfe_pkg::LETTER_X);

  always_comb begin
    pair_nxt.emit   = open_r || in_end_of_text;
    pair_nxt.dup    = split && in_end_of_text;
    pair_nxt.fin    = in_end_of_text;
    pair_nxt.first  = open_r ? held_r : letter_f;
    pair_nxt.second = (!open_r || split) ? pfe_pkg::LETTER_X : letter_f;
    open_nxt        = open_r ? (split && !in_end_of_text) : !in_end_of_text;
    pv_nxt          = accept || (pv_r && !pair_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      held_r <= '0;
      pv_r   <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
      if (accept) begin
        open_r <= open_nxt;
        held_r <= letter_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair_r <= pair_nxt;
    end
  end

  assign pair_valid = pv_r;
  assign pair       = pair_r;

  // The last letter of a message always leaves no letter held.
  a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_text |=> !open_r)
    else $error("pair still open after end of text");

endmodule

`default_nettype wire

[hdl/pfe_cipher.sv]
// Combinational Playfair rule: locates both letters in the loaded square and
// applies the row, column or rectangle rule. Depends on pfe_pkg.
`default_nettype none

module pfe_cipher (
  input  wire pfe_pkg::grid_t   grid,
  input  wire pfe_pkg::letter_t first,
  input  wire pfe_pkg::letter_t second,
  output pfe_pkg::letter_t      cipher_first,
  output pfe_pkg::letter_t      cipher_second
);

  pfe_pkg::coord_t ra, ca, rb, cb;
  pfe_pkg::coord_t oar, oac, obr, obc;

  function automatic pfe_pkg::coord_t wrap_inc(pfe_pkg::coord_t v);
    return (v == pfe_pkg::coord_t'(pfe_pkg::SIDE - 1)) ? '0 : v + 3'd1;
  endfunction

  // Lowest-numbered matching cell wins; a letter with no match sits at cell 0.
  always_comb begin
    ra = '0;
    ca = '0;
    rb = '0;
    cb = '0;
    for (int r = pfe_pkg::SIDE - 1; r >= 0; r--) begin
      for (int c = pfe_pkg::SIDE - 1; c >= 0; c--) begin
        if (pfe_pkg::fold_j(grid[r][c]) == first) begin
          ra = pfe_pkg::coord_t'(r);
          ca = pfe_pkg::coord_t'(c);
        end
        if (pfe_pkg::fold_j(grid[r][c]) == second) begin
          rb = pfe_pkg::coord_t'(r);
          cb = pfe_pkg::coord_t'(c);
        end
      end
    end
  end

  always_comb begin
    if (ra == rb) begin
      oar = ra;
      oac = wrap_inc(ca);
      obr = rb;
      obc = wrap_inc(cb);
    end else if (ca == cb) begin
      oar = wrap_inc(ra);
      oac = ca;
      obr = wrap_inc(rb);
      obc = cb;
    end else begin
      oar = ra;
      oac = cb;
      obr = rb;
      obc = ca;
    end
  end

  assign cipher_first  = grid[oar][oac];
  assign cipher_second = grid[obr][obc];

endmodule

`default_nettype wire

[hdl/pfe_out_queue.sv]
// Four-slot result register that sends one ciphertext letter per transaction.
// Depends on pfe_pkg.
`default_nettype none

module pfe_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire pfe_pkg::q_load_t  load_data,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfe_pkg::letter_t       out_cipher_letter,
  output logic                   out_final_out
);

  localparam int SLOTS = 4;

  logic [2:0]                   cnt_r, cnt_nxt;
  pfe_pkg::letter_t [SLOTS-1:0] let_r;
  logic [SLOTS-1:0]             fin_r;
  logic                         pop;

  assign pop      = (cnt_r != 3'd0) && !out_stall;
  assign can_load = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && !out_stall);

  always_comb begin
    if (load) begin
      cnt_nxt = load_data.dup ? 3'd4 : 3'd2;
    end else if (pop) begin
      cnt_nxt = cnt_r - 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A repeated pair is loaded twice; only the last letter carries the end mark.
  always_ff @(posedge clk) begin
    if (load) begin
      let_r <= {load_data.second, load_data.first, load_data.second, load_data.first};
      fin_r <= {1'b1, 1'b0, load_data.fin && !load_data.dup, 1'b0};
    end else if (pop) begin
      let_r <= {let_r[SLOTS-1], let_r[SLOTS-1:1]};
      fin_r <= {fin_r[SLOTS-1], fin_r[SLOTS-1:1]};
    end
  end

  assign out_valid         = (cnt_r != 3'd0);
  assign out_cipher_letter = let_r[0];
  assign out_final_out     = fin_r[0];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("output queue count out of range");

  a_dup_fills: assert property (@(posedge clk) disable iff (!rst_n)
    load && load_data.dup |=> cnt_r == 3'd4)
    else $error("split pair on last letter did not fill the queue");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_out |-> cnt_r == 3'd1)
    else $error("end mark shown before the queue drains");

endmodule

`default_nettype wire

[hdl/playfair_digraph_encrypt.sv]
// Top level of the Playfair digraph encryptor: configuration registers for
// the square and the three stages. Depends on pfe_pkg, pfe_pair_former,
// pfe_cipher and pfe_out_queue.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | in_letter[4:0], in_end_of_text
//   out     | out_valid/out_stall | out_cipher_letter[4:0], out_final_out
//   cfg     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[49:0]
//
// An input transaction can be taken every cycle while in_stall is low. Each
// letter produces zero, two or four output letters, so the sustained rate is
// set by the output queue, which sends one letter per cycle while out_stall
// is low: a letter that closes a pair sends two letters, a split on the last
// letter four. An input passes the pair register, then the queue registers.
// Reset is synchronous and active low; it clears the square, the held letter
// and all valid state. A stall on the output holds the queue, and once the
// pair register is blocked the input stalls as well.
`default_nettype none

module playfair_digraph_encrypt (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [4:0]          in_letter,
  input  wire logic                in_end_of_text,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [4:0]               out_cipher_letter,
  output logic                     out_final_out,

  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [49:0]         cfg_data
);

  // Square registers. The user must write them only while the block is idle;
  // the block itself does not enforce this, and the port is always ready.
  logic [pfe_pkg::CFG_WIDE_W-1:0]   sq_low_r;
  logic [pfe_pkg::CFG_WIDE_W-1:0]   sq_mid_r;
  logic [pfe_pkg::CFG_NARROW_W-1:0] sq_high_r;
  logic                             cfg_write;
  pfe_pkg::grid_t                   grid;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_low_r  <= '0;
      sq_mid_r  <= '0;
      sq_high_r <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pfe_pkg::CFG_SQUARE_LOW:  sq_low_r  <= cfg_data;
        pfe_pkg::CFG_SQUARE_MID:  sq_mid_r  <= cfg_data;
        pfe_pkg::CFG_SQUARE_HIGH: sq_high_r <= cfg_data[pfe_pkg::CFG_NARROW_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // The three registers concatenate into the row-major packed grid.
  assign grid = {sq_high_r, sq_mid_r, sq_low_r};

  // Pair formation feeds a single pair register. A pair that produces no
  // output leaves at once; otherwise it waits until the queue can take it.
  pfe_pkg::pair_t   pair;
  logic             pair_valid;
  logic             pair_take;
  logic             q_can_load;
  logic             q_load;
  pfe_pkg::q_load_t q_data;
  pfe_pkg::letter_t cipher_first;
  pfe_pkg::letter_t cipher_second;

  assign pair_take = q_can_load || !pair.emit;
  assign q_load    = pair_valid && pair.emit && q_can_load;

  pfe_pair_former u_former (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_letter      (in_letter),
    .in_end_of_text (in_end_of_text),
    .pair_take      (pair_take),
    .pair_valid     (pair_valid),
    .pair           (pair)
  );

  // The cipher rule sits between the pair register and the output queue.
  pfe_cipher u_cipher (
    .grid          (grid),
    .first         (pair.first),
    .second        (pair.second),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second)
  );

  always_comb begin
    q_data.dup    = pair.dup;
    q_data.fin    = pair.fin;
    q_data.first  = cipher_first;
    q_data.second = cipher_second;
  end

  pfe_out_queue u_queue (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (q_load),
    .load_data         (q_data),
    .can_load          (q_can_load),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_final_out     (out_final_out)
  );

endmodule

`default_nettype wire
